>>> hw/rtl/sbswf_pkg.sv
// Package with the types, codes and constants shared by the servo bus frame files.
package sbswf_pkg;

   localparam int SERVO_COUNT_DEFAULT = 2;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int SLOT_BYTES          = 7;

   localparam logic [7:0] SYNC_BYTE      = 8'hFF;
   localparam logic [7:0] BROADCAST_ID   = 8'hFE;
   localparam logic [7:0] CAL_LENGTH     = 8'h02;
   localparam logic [7:0] CAL_INSTR      = 8'h0B;
   localparam logic [7:0] ZERO_BYTE      = 8'h00;
   localparam logic [15:0] SIGN_BIT      = 16'h8000;

   localparam logic [7:0] OPCODE_RESET   = 8'h83;
   localparam logic [7:0] ADDRESS_RESET  = 8'd41;
   localparam logic [7:0] LEFT_ID_RESET  = 8'd1;
   localparam logic [7:0] RIGHT_ID_RESET = 8'd2;

   localparam logic [1:0] ACT_SET       = 2'd0;
   localparam logic [1:0] ACT_MOVE      = 2'd1;
   localparam logic [1:0] ACT_CALIBRATE = 2'd2;
   localparam logic [1:0] ACT_NONE      = 2'd3;

   localparam logic [1:0] CSR_OPCODE   = 2'd0;
   localparam logic [1:0] CSR_ADDRESS  = 2'd1;
   localparam logic [1:0] CSR_LEFT_ID  = 2'd2;
   localparam logic [1:0] CSR_RIGHT_ID = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         servo_id;
      logic signed [15:0] position;
      logic [15:0]        speed;
      logic [7:0]         acceleration;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] position;
      logic [15:0] speed;
      logic [7:0]  acceleration;
   } target_type;

   typedef struct packed {
      logic       is_move;
      logic [7:0] id;
   } cmd_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] address;
   } cfg_type;

endpackage

>>> hw/rtl/servo_bus_sync_write_framer.sv
// Top level of the servo bus sync-write framer.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_push/req_full  req_data (action, id, targets)
//   rsp_      out        rsp_empty/rsp_pop  rsp_data (out_byte, last_byte)
//   csr_      in         csr_valid/ready    csr_index, csr_wdata
//
// A frame leaves one byte per cycle while results are taken: 8*SERVO_COUNT+8 bytes for a
// move, six for a calibrate. Each frame starts once its command leaves the queue; the byte
// sequencer in the back sets the rate. A set item queues no command. Every item is held off
// from the transfer of a move until its checksum byte is produced. Reset is synchronous and
// restores the registers and zero targets. Result stalls hold the byte sequencer; input
// stalls while the queue is full or a move frame is pending.
module servo_bus_sync_write_framer #(
   parameter int SERVO_COUNT = sbswf_pkg::SERVO_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH = sbswf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  sbswf_pkg::req_type req_data,
   output logic               req_full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output sbswf_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   sbswf_pkg::cmd_type    push_cmd;
   sbswf_pkg::cmd_type    pop_cmd;
   sbswf_pkg::target_type targets [SERVO_COUNT];
   sbswf_pkg::cfg_type    cfg;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_empty;
   logic                  move_done;

   sbswf_front #(
      .SERVO_COUNT(SERVO_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_data    (push_cmd),
      .q_full    (q_full),
      .move_done (move_done),
      .targets   (targets),
      .cfg       (cfg)
   );

   sbswf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   sbswf_back #(
      .SERVO_COUNT(SERVO_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (pop_cmd),
      .targets   (targets),
      .cfg       (cfg),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .move_done (move_done)
   );

endmodule

>>> hw/rtl/sbswf_queue.sv
// Short command queue between the front and the back of the servo bus framer.
module sbswf_queue #(
   parameter int DEPTH = sbswf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sbswf_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output sbswf_pkg::cmd_type pop_data,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sbswf_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/sbswf_front.sv
// Front of the servo bus framer: accepts items, keeps the target records and registers.
module sbswf_front #(
   parameter int SERVO_COUNT = sbswf_pkg::SERVO_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  sbswf_pkg::req_type    req_data,
   output logic                  req_full,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   output logic                  q_push,
   output sbswf_pkg::cmd_type    q_data,
   input  logic                  q_full,
   input  logic                  move_done,
   output sbswf_pkg::target_type targets [SERVO_COUNT],
   output sbswf_pkg::cfg_type    cfg
);

   sbswf_pkg::target_type cur_ff  [SERVO_COUNT];
   sbswf_pkg::target_type cur_in  [SERVO_COUNT];
   sbswf_pkg::target_type prev_ff [SERVO_COUNT];
   sbswf_pkg::target_type prev_in [SERVO_COUNT];
   sbswf_pkg::target_type new_rec;
   logic [7:0]            opcode_ff;
   logic [7:0]            address_ff;
   logic [7:0]            left_id_ff;
   logic [7:0]            right_id_ff;
   logic                  move_out_ff;
   logic                  move_out_in;
   logic                  accept;
   logic                  hit_left;
   logic                  hit_right;
   logic                  changed;

   assign csr_ready   = 1'b1;
   assign req_full    = q_full || move_out_ff;
   assign accept      = req_push && !req_full;
   assign hit_left    = (req_data.servo_id == left_id_ff);
   assign hit_right   = (SERVO_COUNT > 1) && !hit_left && (req_data.servo_id == right_id_ff);
   assign cfg.opcode  = opcode_ff;
   assign cfg.address = address_ff;

   assign new_rec.id           = req_data.servo_id;
   assign new_rec.position     = req_data.position;
   assign new_rec.speed        = req_data.speed;
   assign new_rec.acceleration = req_data.acceleration;

   always_comb begin
      changed = 1'b0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
         targets[i] = cur_ff[i];
         if (cur_ff[i] != prev_ff[i]) begin
            changed = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
         cur_in[i]  = cur_ff[i];
         prev_in[i] = prev_ff[i];
         if (accept && (req_data.action == sbswf_pkg::ACT_SET) &&
             (((i == 0) && hit_left) || ((i == 1) && hit_right))) begin
            prev_in[i] = cur_ff[i];
            cur_in[i]  = new_rec;
         end
      end
   end

   always_comb begin
      q_push    = 1'b0;
      q_data.id = req_data.servo_id;
      q_data.is_move = 1'b0;
      unique case (req_data.action)
         sbswf_pkg::ACT_MOVE: begin
            q_push         = accept && changed;
            q_data.is_move = 1'b1;
         end
         sbswf_pkg::ACT_CALIBRATE: begin
            q_push = accept;
         end
         sbswf_pkg::ACT_SET, sbswf_pkg::ACT_NONE: begin
            q_push = 1'b0;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_comb begin
      move_out_in = move_out_ff;
      if (move_done) begin
         move_out_in = 1'b0;
      end else if (q_push && q_data.is_move) begin
         move_out_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff   <= sbswf_pkg::OPCODE_RESET;
         address_ff  <= sbswf_pkg::ADDRESS_RESET;
         left_id_ff  <= sbswf_pkg::LEFT_ID_RESET;
         right_id_ff <= sbswf_pkg::RIGHT_ID_RESET;
         move_out_ff <= 1'b0;
         for (int i = 0; i < SERVO_COUNT; i++) begin
            cur_ff[i]  <= '0;
            prev_ff[i] <= '0;
         end
      end else begin
         move_out_ff <= move_out_in;
         for (int i = 0; i < SERVO_COUNT; i++) begin
            cur_ff[i]  <= cur_in[i];
            prev_ff[i] <= prev_in[i];
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               sbswf_pkg::CSR_OPCODE:   opcode_ff   <= csr_wdata;
               sbswf_pkg::CSR_ADDRESS:  address_ff  <= csr_wdata;
               sbswf_pkg::CSR_LEFT_ID:  left_id_ff  <= csr_wdata;
               sbswf_pkg::CSR_RIGHT_ID: right_id_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // A pending move frame reads the target records, so no item enters until it is sent.
   a_move_blocks_input: assert property (@(posedge clock) disable iff (reset)
      move_out_ff |-> req_full)
      else $error("item accepted while a move frame is pending");

   a_move_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(move_out_ff) |-> $past(q_push && q_data.is_move))
      else $error("move pending without a queued move");

endmodule

>>> hw/rtl/sbswf_back.sv
// Back of the servo bus framer: streams frame bytes into the result register.
module sbswf_back #(
   parameter int SERVO_COUNT = sbswf_pkg::SERVO_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  sbswf_pkg::cmd_type    q_data,
   input  sbswf_pkg::target_type targets [SERVO_COUNT],
   input  sbswf_pkg::cfg_type    cfg,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output sbswf_pkg::rsp_type    rsp_data,
   output logic                  move_done
);

   localparam int SLOT_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam logic [7:0] LEN_BYTE = 8'((sbswf_pkg::SLOT_BYTES + 1) * SERVO_COUNT + 4);
   localparam logic [7:0] SLOT_BYTE_COUNT = 8'(sbswf_pkg::SLOT_BYTES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HDR  = 3'd1;
   localparam logic [2:0] ST_DATA = 3'd2;
   localparam logic [2:0] ST_CAL  = 3'd3;
   localparam logic [2:0] ST_CHK  = 3'd4;

   logic [2:0]            state_ff;
   logic [2:0]            state_in;
   logic                  kind_ff;
   logic                  kind_in;
   logic [7:0]            id_ff;
   logic [7:0]            id_in;
   logic [2:0]            idx_ff;
   logic [2:0]            idx_in;
   logic [2:0]            sub_ff;
   logic [2:0]            sub_in;
   logic [SLOT_W-1:0]     slot_ff;
   logic [SLOT_W-1:0]     slot_in;
   logic [7:0]            sum_ff;
   logic [7:0]            sum_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   sbswf_pkg::rsp_type    out_ff;
   logic                  step;
   logic                  add_sum;
   logic [7:0]            byte_val;
   logic                  last_val;
   sbswf_pkg::target_type rec;
   logic [15:0]           pos_sm;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign step      = (state_ff != ST_IDLE) && (!out_valid_ff || rsp_pop);
   assign rec       = targets[slot_ff];
   assign pos_sm    = rec.position[15] ? ((~rec.position + 16'd1) | sbswf_pkg::SIGN_BIT)
                                       : rec.position;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      id_in     = id_ff;
      idx_in    = idx_ff;
      sub_in    = sub_ff;
      slot_in   = slot_ff;
      q_pop     = 1'b0;
      add_sum   = 1'b0;
      byte_val  = sbswf_pkg::SYNC_BYTE;
      last_val  = 1'b0;
      move_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               kind_in  = q_data.is_move;
               id_in    = q_data.id;
               idx_in   = '0;
               sub_in   = '0;
               slot_in  = '0;
               state_in = q_data.is_move ? ST_HDR : ST_CAL;
            end
         end
         ST_HDR: begin
            add_sum = (idx_ff >= 3'd2);
            unique case (idx_ff)
               3'd0, 3'd1: byte_val = sbswf_pkg::SYNC_BYTE;
               3'd2:       byte_val = sbswf_pkg::BROADCAST_ID;
               3'd3:       byte_val = LEN_BYTE;
               3'd4:       byte_val = cfg.opcode;
               3'd5:       byte_val = cfg.address;
               default:    byte_val = SLOT_BYTE_COUNT;
            endcase
            if (step) begin
               if (idx_ff == 3'd6) begin
                  state_in = ST_DATA;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         ST_DATA: begin
            add_sum = 1'b1;
            unique case (sub_ff)
               3'd0:       byte_val = rec.id;
               3'd1:       byte_val = rec.acceleration;
               3'd2:       byte_val = pos_sm[7:0];
               3'd3:       byte_val = pos_sm[15:8];
               3'd4, 3'd5: byte_val = sbswf_pkg::ZERO_BYTE;
               3'd6:       byte_val = rec.speed[7:0];
               default:    byte_val = rec.speed[15:8];
            endcase
            if (step) begin
               sub_in = sub_ff + 3'd1;
               if (sub_ff == 3'd7) begin
                  if (slot_ff == SLOT_W'(SERVO_COUNT - 1)) begin
                     state_in = ST_CHK;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                  end
               end
            end
         end
         ST_CAL: begin
            add_sum = (idx_ff >= 3'd2);
            unique case (idx_ff)
               3'd0, 3'd1: byte_val = sbswf_pkg::SYNC_BYTE;
               3'd2:       byte_val = id_ff;
               3'd3:       byte_val = sbswf_pkg::CAL_LENGTH;
               default:    byte_val = sbswf_pkg::CAL_INSTR;
            endcase
            if (step) begin
               if (idx_ff == 3'd4) begin
                  state_in = ST_CHK;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         ST_CHK: begin
            byte_val = ~sum_ff;
            last_val = 1'b1;
            if (step) begin
               state_in  = ST_IDLE;
               move_done = kind_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      sum_in = sum_ff;
      if (state_ff == ST_IDLE) begin
         sum_in = '0;
      end else if (step && add_sum) begin
         sum_in = sum_ff + byte_val;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      id_ff   <= id_in;
      idx_ff  <= idx_in;
      sub_ff  <= sub_in;
      slot_ff <= slot_in;
      sum_ff  <= sum_in;
      if (step) begin
         out_ff.out_byte  <= byte_val;
         out_ff.last_byte <= last_val;
      end
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && !q_empty)
      else $error("command taken while a frame is in progress");

   a_done_ends_frame: assert property (@(posedge clock) disable iff (reset)
      move_done |=> (state_ff == ST_IDLE) && out_valid_ff && out_ff.last_byte)
      else $error("move frame finished without its checksum transfer");

   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop && (state_ff != ST_IDLE)) |=> $stable(out_ff))
      else $error("stalled result overwritten");

endmodule
